FILE: rtl/core/rsm5_pkg.sv
package rsm5_pkg;

	localparam int CHANNELS = 6;
	localparam int WINDOW   = 5;

	localparam int CH_W   = 3;
	localparam int DIST_W = 16;
	localparam int SAMP_W = 15;
	localparam int POS_W  = $clog2(WINDOW);
	localparam int RANK_W = $clog2(WINDOW);

	// Rank of the median among WINDOW samples, counted from zero.
	localparam int MED_RANK = WINDOW / 2;

	localparam logic [SAMP_W-1:0] MAX_RANGE_RESET = SAMP_W'(400);

	// The out-of-range code.
	localparam logic [DIST_W-1:0] NO_RANGE = '1;

	typedef logic [SAMP_W-1:0] sample_t;
	typedef logic [WINDOW-1:0][SAMP_W-1:0] window_t;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            wr;
		sample_t         sample;
	} st_req_t;

	typedef struct packed {
		logic    full;
		window_t row;
	} st_resp_t;

endpackage

FILE: rtl/core/rsm5_median.sv
module rsm5_median (
	input  rsm5_pkg::window_t v,
	output rsm5_pkg::sample_t med
);
	import rsm5_pkg::*;

	// Each sample gets a stable rank: ties are broken by position, so the
	// ranks form a permutation and exactly one sample holds the median rank.
	always_comb begin
		logic [RANK_W-1:0] rank;
		sample_t           acc;
		acc = '0;
		for (int i = 0; i < WINDOW; i++) begin
			rank = '0;
			for (int j = 0; j < WINDOW; j++) begin
				if (j != i) begin
					if ((v[j] < v[i]) || ((v[j] == v[i]) && (j < i))) begin
						rank = rank + RANK_W'(1);
					end
				end
			end
			if (rank == RANK_W'(MED_RANK)) begin
				acc = acc | v[i];
			end
		end
		med = acc;
	end

endmodule

FILE: rtl/core/rsm5_chan_state.sv
module rsm5_chan_state (
	input  logic               clk,
	input  logic               arst_n,
	input  rsm5_pkg::st_req_t  req,
	output rsm5_pkg::st_resp_t resp
);
	import rsm5_pkg::*;

	window_t          store_q [CHANNELS];
	logic [POS_W-1:0] pos_q [CHANNELS];
	logic [CHANNELS-1:0] full_q;

	logic             ch_ok;
	logic [CH_W-1:0]  idx;
	logic             wr;
	logic [POS_W-1:0] wpos;
	logic             wrap;
	logic [POS_W-1:0] pos_next;

	assign ch_ok = (32'(req.ch) < CHANNELS);
	assign idx   = ch_ok ? req.ch : '0;
	assign wr    = req.wr && ch_ok;

	assign wpos     = (32'(pos_q[idx]) >= WINDOW) ? '0 : pos_q[idx];
	assign wrap     = (wpos == POS_W'(WINDOW - 1));
	assign pos_next = wrap ? '0 : wpos + POS_W'(1);

	// The row as it stands after this word's sample goes in.
	always_comb begin
		for (int k = 0; k < WINDOW; k++) begin
			if (wr && (wpos == POS_W'(k))) begin
				resp.row[k] = req.sample;
			end else begin
				resp.row[k] = store_q[idx][k];
			end
		end
		resp.full = ch_ok && (full_q[idx] || (wr && wrap));
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			store_q[idx][wpos] <= req.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				pos_q[c] <= '0;
			end
			full_q <= '0;
		end else if (wr) begin
			pos_q[idx] <= pos_next;
			if (wrap) begin
				full_q[idx] <= 1'b1;
			end
		end
	end

	// Once a channel has warmed up it never goes back.
	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(full_q) == ($past(full_q) & full_q))
		else $error("window full flag dropped");

	// The ring position of the addressed channel never leaves the window.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		ch_ok |-> (32'(pos_q[idx]) < WINDOW))
		else $error("write position outside the window");

	// A channel reporting full stays full while it is not written.
	a_full_written: assert property (@(posedge clk) disable iff (!arst_n)
		(ch_ok && full_q[idx] && !wr) |=> full_q[$past(idx)])
		else $error("full flag lost without a write");

endmodule

FILE: rtl/core/range_sensor_median5_filter_unit.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    channel, raw_distance
// out       output     out_valid / out_ready  filtered_distance
// cfg       input      cfg_valid / cfg_ready  max_range_cm
//
// The range check feeds the input register, then ring update and a
// five-sample rank network feed the result register. One word is accepted
// per cycle while out_ready stays high. Reset clears all ring positions and
// warm-up flags and sets the range limit to 400; ring contents are not
// reset. A stall on the output holds the result register and lets at most
// one more word into the input register.
module range_sensor_median5_filter_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rsm5_pkg::CH_W-1:0]      channel,
	input  logic signed [rsm5_pkg::DIST_W-1:0] raw_distance,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [rsm5_pkg::DIST_W-1:0] filtered_distance,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rsm5_pkg::SAMP_W-1:0]    max_range_cm
);
	import rsm5_pkg::*;

	sample_t             max_range_q;
	logic                valid_s1;
	logic [CH_W-1:0]     ch_s1;
	logic [DIST_W-1:0]   dist_s1;
	logic                out_valid_q;
	logic [DIST_W-1:0]   res_q;

	logic                go_s1;
	logic [DIST_W-1:0]   checked;
	st_req_t             st_req;
	st_resp_t            st_resp;
	sample_t             med;
	logic [DIST_W-1:0]   result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_range_q <= MAX_RANGE_RESET;
		end else if (cfg_valid) begin
			max_range_q <= max_range_cm;
		end
	end

	assign go_s1    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || go_s1;

	assign checked = ($signed(raw_distance) > $signed({1'b0, max_range_q})) ?
		NO_RANGE : raw_distance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1   <= channel;
			dist_s1 <= checked;
		end
	end

	// Negative readings, including the out-of-range code, are never stored.
	assign st_req.ch     = ch_s1;
	assign st_req.wr     = go_s1 && !dist_s1[DIST_W-1];
	assign st_req.sample = dist_s1[SAMP_W-1:0];

	rsm5_chan_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (st_req),
		.resp   (st_resp)
	);

	rsm5_median u_median (
		.v   (st_resp.row),
		.med (med)
	);

	assign result = st_resp.full ? {1'b0, med} : dist_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			res_q <= result;
		end
	end

	assign out_valid         = out_valid_q;
	assign filtered_distance = res_q;

	// With the result register empty the input side never stalls.
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty output");

	// A word in the input register moves on when the output is free.
	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_valid_q) |=> out_valid_q)
		else $error("word stuck in the input register");

	// A median result is never negative.
	a_median_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s1 && st_resp.full) |=> !res_q[DIST_W-1])
		else $error("negative median");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import rsm5_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [CH_W-1:0]          channel;
	logic signed [DIST_W-1:0] raw_distance;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [DIST_W-1:0] filtered_distance;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [SAMP_W-1:0]        max_range_cm;

	// When set, neither side inserts idle cycles.
	bit calm;
	int quiet_cycles = 0;

	range_sensor_median5_filter_unit u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.channel           (channel),
		.raw_distance      (raw_distance),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.filtered_distance (filtered_distance),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.max_range_cm      (max_range_cm)
	);

	class median_scoreboard;
		sample_t                  range_limit;
		sample_t                  ring [CHANNELS][WINDOW];
		logic [POS_W-1:0]         slot [CHANNELS];
		bit                       warm [CHANNELS];
		logic signed [DIST_W-1:0] expected_distance_q [$];
		int                       mismatch_count;

		function new();
			range_limit = MAX_RANGE_RESET;
			mismatch_count = 0;
			for (int c = 0; c < CHANNELS; c++) begin
				slot[c] = '0;
				warm[c] = 1'b0;
				for (int i = 0; i < WINDOW; i++) ring[c][i] = '0;
			end
		endfunction

		function sample_t window_median(int c);
			sample_t v [WINDOW];
			sample_t key;
			int j;
			for (int i = 0; i < WINDOW; i++) v[i] = ring[c][i];
			for (int i = 1; i < WINDOW; i++) begin
				key = v[i];
				j = i - 1;
				while (j >= 0 && v[j] > key) begin
					v[j + 1] = v[j];
					j--;
				end
				v[j + 1] = key;
			end
			return v[MED_RANK];
		endfunction

		function void note_reading(logic [CH_W-1:0] ch,
				logic signed [DIST_W-1:0] raw);
			int reading;
			int c;
			logic signed [DIST_W-1:0] result;
			reading = int'(raw);
			if (reading > int'(range_limit)) reading = -1;
			result = DIST_W'(reading);
			if (ch < CHANNELS) begin
				c = int'(ch);
				// Only non-negative readings enter the ring; the first wrap
				// enables the median.
				if (reading >= 0) begin
					ring[c][slot[c]] = sample_t'(reading);
					if (slot[c] == POS_W'(WINDOW - 1)) begin
						slot[c] = '0;
						warm[c] = 1'b1;
					end else begin
						slot[c] = slot[c] + 1'b1;
					end
				end
				if (warm[c]) result = {1'b0, window_median(c)};
			end
			expected_distance_q.push_back(result);
		endfunction

		function void check_distance(logic signed [DIST_W-1:0] got);
			logic signed [DIST_W-1:0] want;
			if (expected_distance_q.size() == 0) begin
				$error("filtered_distance: no word expected, actual %0d", got);
				mismatch_count++;
			end else begin
				want = expected_distance_q.pop_front();
				if (got !== want) begin
					$error("filtered_distance: expected %0d, actual %0d", want, got);
					mismatch_count++;
				end
			end
		endfunction
	endclass

	median_scoreboard sb;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Result side: random back-pressure.
	always @(negedge clk) begin
		if (arst_n) begin
			out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 14);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_distance(filtered_distance);
		end
	end

	// Watchdog: the run ends if nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_reading(input logic [CH_W-1:0] ch, input logic signed [DIST_W-1:0] d);
		if (!calm) begin
			while ($urandom_range(99) < 14) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid     <= 1'b1;
		channel      <= ch;
		raw_distance <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_reading(ch, d);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.expected_distance_q.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_range_limit(input sample_t lim);
		cfg_valid    <= 1'b1;
		max_range_cm <= lim;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.range_limit = lim;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [DIST_W-1:0] random_reading(sample_t lim);
		int pick;
		int hi;
		pick = $urandom_range(99);
		hi = int'(lim);
		if (pick < 66) return DIST_W'($urandom_range(hi, 0));
		if (pick < 74) return NO_RANGE;
		if (pick < 82) begin
			if (hi < 32767) return DIST_W'($urandom_range(32767, hi + 1));
			return DIST_W'($urandom);
		end
		if (pick < 92) return DIST_W'($urandom);
		return pick[0] ? DIST_W'(hi) : '0;
	endfunction

	task automatic run_readings(input int n);
		logic [CH_W-1:0] ch;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < 90) ch = CH_W'($urandom_range(CHANNELS - 1, 0));
			else ch = CH_W'($urandom_range(7, CHANNELS));
			send_reading(ch, random_reading(sb.range_limit));
		end
	endtask

	initial begin
		sb = new();
		calm = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		channel = '0;
		raw_distance = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		max_range_cm = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Warm-up on channel 0 with the reset limit of 400, including the limit
		// itself, one above it, the no-echo code and other negative readings.
		send_reading(3'd0, 16'sd0);
		send_reading(3'd0, 16'sd400);
		send_reading(3'd0, 16'sd401);
		send_reading(3'd0, NO_RANGE);
		send_reading(3'd0, -16'sd32768);
		send_reading(3'd0, 16'sd32767);
		send_reading(3'd0, 16'sd7);
		send_reading(3'd0, 16'sd123);
		send_reading(3'd0, 16'sd399);
		// Channel 0 is now warm: rejected and negative readings return the median.
		send_reading(3'd0, NO_RANGE);
		send_reading(3'd0, -16'sd2);
		send_reading(3'd0, 16'sd500);
		send_reading(3'd0, 16'sd5);
		// Channels past the last one never touch state.
		send_reading(3'd6, 16'sd20);
		send_reading(3'd7, 16'sd32767);
		send_reading(3'd7, -16'sd5);
		send_reading(3'd5, 16'sd400);
		send_reading(3'd5, 16'sd400);
		send_reading(3'd1, NO_RANGE);
		send_reading(3'd2, 16'sd1);
		send_reading(3'd3, 16'sd255);
		send_reading(3'd4, 16'sd16383);
		run_readings(230);
		drain_results();

		write_range_limit(sample_t'(32767));
		calm = 1'b1;
		run_readings(120);
		calm = 1'b0;
		run_readings(80);
		drain_results();

		write_range_limit('0);
		run_readings(100);
		drain_results();

		write_range_limit(sample_t'($urandom_range(32766, 1)));
		run_readings(250);
		drain_results();

		write_range_limit(sample_t'(15));
		run_readings(250);
		drain_results();

		repeat (10) @(posedge clk);
		if (sb.expected_distance_q.size() != 0) begin
			$error("filtered_distance: %0d expected words never arrived",
				sb.expected_distance_q.size());
			sb.mismatch_count++;
		end
		if (sb.mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
